### design/gpe_pkg.sv
// ----------------------------------------------------------------------------
// gpe_pkg
// Shared types, constants and GF(2^16) arithmetic for the polynomial
// evaluator.
// ----------------------------------------------------------------------------
package gpe_pkg;

  localparam int COEF_W       = 16;
  localparam int INDEX_W      = 12;
  localparam int TERM_COUNT_W = 13;
  localparam int MAX_TERMS_DEF = 4096;

  localparam logic [TERM_COUNT_W-1:0] TERM_COUNT_RST = TERM_COUNT_W'(4096);
  // x^16 + x^15 + x^12 + x^10 + 1
  localparam logic [COEF_W:0] FIELD_MODULUS = 17'h19401;

  typedef enum logic {
    OP_LOAD = 1'b0,
    OP_EVAL = 1'b1
  } op_e;

  // controller -> datapath
  typedef struct packed {
    logic clr_step;    // write zero at sweep address, advance
    logic load_wr;     // write the accepted coefficient
    logic eval_start;  // latch point, clear accumulator, set start index
    logic issue;       // read coefficient at index, step index down
    logic out_load;    // move accumulator into the result register
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic idx_zero;
    logic idx_last;
    logic cnt_zero;
  } sts_t;

  // x^k mod P for k < 31
  function automatic logic [COEF_W-1:0] gf_xpow(int k);
    logic [COEF_W:0] r;
    r = 17'd1;
    for (int i = 0; i < 30; i++) begin
      if (i < k) begin
        r = r << 1;
        if (r[COEF_W]) begin
          r = r ^ FIELD_MODULUS;
        end
      end
    end
    return r[COEF_W-1:0];
  endfunction

  // Carry-less product, then reduction of the upper bits through constant
  // residues; both halves are flat XOR trees.
  function automatic logic [COEF_W-1:0] gf_mul(logic [COEF_W-1:0] a,
                                               logic [COEF_W-1:0] b);
    logic [2*COEF_W-2:0] prod;
    logic [COEF_W-1:0]   res;
    prod = '0;
    for (int j = 0; j < COEF_W; j++) begin
      if (b[j]) begin
        prod = prod ^ ({{(COEF_W-1){1'b0}}, a} << j);
      end
    end
    res = prod[COEF_W-1:0];
    for (int k = COEF_W; k < 2*COEF_W-1; k++) begin
      if (prod[k]) begin
        res = res ^ gf_xpow(k);
      end
    end
    return res;
  endfunction

endpackage

### design/gf16_poly_eval.sv
// ----------------------------------------------------------------------------
// gf16_poly_eval
// Polynomial evaluation over GF(2^16) (modulus 0x19401) in Horner order.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_stall_o) carries one request with fields
//   operation, coef_index, coef_value and point. A load writes one
//   coefficient (indexes beyond the store are dropped) and
//   gives no result. An evaluate returns one value on the output channel
//   (out_valid_o / out_stall_i).
//   An evaluate runs with n = min(term_count, MAX_TERMS): RUN reads the
//   coefficients from index n - 1 down to 0, DRAIN takes the last one back
//   and FINISH moves the result out (n zero goes straight to FINISH). The
//   store has one port and the loop does one multiply-accumulate per
//   coefficient read, so the next request is taken only after the evaluate,
//   later while the previous result still waits. A load leaves in_stall_o low.
//   Config channel (cfg_valid_i / cfg_ready_o) writes term_count, reset 4096;
//   write it only while no evaluate is in flight.
//   After reset all MAX_TERMS entries of the store are swept to zero, during
//   which in_stall_o stays high.
//   A finished result sits in an output register; new requests are taken
//   while it waits. If the receiver stalls, the next evaluate completes its
//   reads and then holds until the register is free.
// ----------------------------------------------------------------------------
module gf16_poly_eval #(
  parameter int MAX_TERMS = gpe_pkg::MAX_TERMS_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  logic                             operation_i,
  input  logic [gpe_pkg::INDEX_W-1:0]      coef_index_i,
  input  logic [gpe_pkg::COEF_W-1:0]       coef_value_i,
  input  logic [gpe_pkg::COEF_W-1:0]       point_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic [gpe_pkg::COEF_W-1:0]       value_o,
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [gpe_pkg::TERM_COUNT_W-1:0] cfg_term_count_i
);

  import gpe_pkg::*;

  cmd_t cmd;
  sts_t sts;

  assign cfg_ready_o = 1'b1;

  gpe_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .operation_i (operation_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cmd_o       (cmd),
    .sts_i       (sts)
  );

  gpe_datapath #(
    .MAX_TERMS (MAX_TERMS)
  ) u_datapath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .sts_o            (sts),
    .cfg_we_i         (cfg_valid_i & cfg_ready_o),
    .cfg_term_count_i (cfg_term_count_i),
    .coef_index_i     (coef_index_i),
    .coef_value_i     (coef_value_i),
    .point_i          (point_i),
    .value_o          (value_o)
  );

endmodule

### design/gpe_ram.sv
// ----------------------------------------------------------------------------
// gpe_ram
// Generic single-port RAM, one write or read per cycle, registered read.
// ----------------------------------------------------------------------------
module gpe_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 4096
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_q <= mem_q[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### design/gpe_datapath.sv
// ----------------------------------------------------------------------------
// gpe_datapath
// Coefficient store, index counter, Horner accumulator, term count register
// and result register.
// ----------------------------------------------------------------------------
module gpe_datapath #(
  parameter int MAX_TERMS = gpe_pkg::MAX_TERMS_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  gpe_pkg::cmd_t                     cmd_i,
  output gpe_pkg::sts_t                     sts_o,
  input  logic                              cfg_we_i,
  input  logic [gpe_pkg::TERM_COUNT_W-1:0]  cfg_term_count_i,
  input  logic [gpe_pkg::INDEX_W-1:0]       coef_index_i,
  input  logic [gpe_pkg::COEF_W-1:0]        coef_value_i,
  input  logic [gpe_pkg::COEF_W-1:0]        point_i,
  output logic [gpe_pkg::COEF_W-1:0]        value_o
);

  import gpe_pkg::*;

  localparam int AW = $clog2(MAX_TERMS);

  logic [TERM_COUNT_W-1:0] term_count_q;
  logic [AW-1:0]           idx_q, idx_d;
  logic [COEF_W-1:0]       pt_q;
  logic [COEF_W-1:0]       acc_q, acc_d;
  logic [COEF_W-1:0]       value_q;
  logic                    rd_pend_q;

  logic [31:0]       tc_ext, n_ext, ld_ext;
  logic              ld_ok;
  logic              ram_we;
  logic [AW-1:0]     ram_addr;
  logic [COEF_W-1:0] ram_wdata, ram_rdata;

  // effective term count, saturated to the store depth
  assign tc_ext = 32'(term_count_q);
  assign n_ext  = (tc_ext > 32'(MAX_TERMS)) ? 32'(MAX_TERMS) : tc_ext;
  assign ld_ext = 32'(coef_index_i);
  assign ld_ok  = ld_ext < 32'(MAX_TERMS);

  assign ram_we    = cmd_i.clr_step | (cmd_i.load_wr & ld_ok);
  assign ram_addr  = cmd_i.load_wr ? ld_ext[AW-1:0] : idx_q;
  assign ram_wdata = cmd_i.clr_step ? '0 : coef_value_i;

  gpe_ram #(
    .WIDTH (COEF_W),
    .DEPTH (MAX_TERMS)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .addr_i  (ram_addr),
    .wdata_i (ram_wdata),
    .rdata_o (ram_rdata)
  );

  always_comb begin
    idx_d = idx_q;
    if (cmd_i.eval_start) begin
      idx_d = AW'(n_ext - 32'd1);
    end else if (cmd_i.clr_step) begin
      idx_d = idx_q + AW'(1);
    end else if (cmd_i.issue) begin
      idx_d = idx_q - AW'(1);
    end
  end

  // one Horner step per returned coefficient
  always_comb begin
    acc_d = acc_q;
    if (cmd_i.eval_start) begin
      acc_d = '0;
    end else if (rd_pend_q) begin
      acc_d = gf_mul(acc_q, pt_q) ^ ram_rdata;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      term_count_q <= TERM_COUNT_RST;
      idx_q        <= '0;
      rd_pend_q    <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        term_count_q <= cfg_term_count_i;
      end
      idx_q     <= idx_d;
      rd_pend_q <= cmd_i.issue;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
    if (cmd_i.eval_start) begin
      pt_q <= point_i;
    end
    if (cmd_i.out_load) begin
      value_q <= acc_q;
    end
  end

  assign sts_o.idx_zero = (idx_q == '0);
  assign sts_o.idx_last = (idx_q == AW'(MAX_TERMS - 1));
  assign sts_o.cnt_zero = (n_ext == 32'd0);

  assign value_o = value_q;

endmodule

### design/gpe_ctrl.sv
// ----------------------------------------------------------------------------
// gpe_ctrl
// Sequencer: store clear after reset, load/evaluate dispatch, read issue,
// and the result valid flag.
// ----------------------------------------------------------------------------
module gpe_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  logic          operation_i,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output gpe_pkg::cmd_t cmd_o,
  input  gpe_pkg::sts_t sts_i
);

  import gpe_pkg::*;

  typedef enum logic [4:0] {
    S_CLEAR  = 5'b00001,
    S_IDLE   = 5'b00010,
    S_RUN    = 5'b00100,
    S_DRAIN  = 5'b01000,
    S_FINISH = 5'b10000
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      S_CLEAR: begin
        cmd_o.clr_step = 1'b1;
        if (sts_i.idx_last) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid_i) begin
          if (op_e'(operation_i) == OP_EVAL) begin
            cmd_o.eval_start = 1'b1;
            state_d = sts_i.cnt_zero ? S_FINISH : S_RUN;
          end else begin
            cmd_o.load_wr = 1'b1;
          end
        end
      end
      S_RUN: begin
        cmd_o.issue = 1'b1;
        if (sts_i.idx_zero) begin
          state_d = S_DRAIN;
        end
      end
      S_DRAIN: begin
        // last coefficient comes back from the store this cycle
        state_d = S_FINISH;
      end
      S_FINISH: begin
        if (!out_valid_q || !out_stall_i) begin
          cmd_o.out_load = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.out_load) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;

endmodule
